### design/dfp_pkg.sv
// Shared types and constants for the dip-from-peak trigger.
package dfp_pkg;

  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int DEF_WARMUP       = 50;
  localparam int DEF_PRICE_BITS   = 32;

  localparam int LOOKBACK_BITS  = 7;
  localparam int THRESHOLD_BITS = 14;
  localparam int CFG_DATA_BITS  = 14;
  localparam int PEAK_OUT_BITS  = 32;
  localparam int FLAG_BITS      = 3;

  localparam logic [LOOKBACK_BITS-1:0]  LOOKBACK_RST  = 7'd24;
  localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RST = 14'd200;

  // Fixed-point scale factors and the target gain in percent
  localparam logic [13:0] BP_ONE          = 14'd10000;
  localparam logic [6:0]  PCT_ONE         = 7'd100;
  localparam logic [1:0]  TARGET_GAIN_PCT = 2'd3;

  typedef enum logic [0:0] {
    REG_LOOKBACK  = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_MUL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic mul;
    logic fin;
  } dfp_cmd_t;

  typedef struct packed {
    logic filled;
    logic scan_last;
  } dfp_sts_t;

endpackage

### design/dip_from_peak_entry_exit_trigger.sv
// Top level of the dip-from-peak entry and exit trigger.
// Each input word carries a closing price, a holding flag and an entry price, and
// produces one result word. For a filled window the single read port of the price ring
// returns one stored price per cycle to one shared comparator over the lookback prices,
// followed by the drain, multiply and finish states. Before the window holds lookback
// prices the word skips the scan and drain states. A new word is accepted while the
// previous result still waits in the output register. The ring needs no clearing.
module dip_from_peak_entry_exit_trigger #(
  parameter int WINDOW_DEPTH = dfp_pkg::DEF_WINDOW_DEPTH,
  parameter int WARMUP       = dfp_pkg::DEF_WARMUP,
  parameter int PRICE_BITS   = dfp_pkg::DEF_PRICE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_addr,
  input  logic [dfp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // close_price, entry_price, zero fill
  input  logic [((2*PRICE_BITS+7)/8)*8-1:0] in_tdata,
  // holding
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // window_peak
  output logic [dfp_pkg::PEAK_OUT_BITS-1:0] out_tdata,
  // buy_signal, sell_signal, sell_reason
  output logic [dfp_pkg::FLAG_BITS-1:0]     out_tuser
);

  dfp_pkg::dfp_cmd_t cmd;
  dfp_pkg::dfp_sts_t sts;

  dfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dfp_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .WARMUP       (WARMUP),
    .PRICE_BITS   (PRICE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .close_price (in_tdata[PRICE_BITS-1:0]),
    .holding     (in_tuser),
    .entry_price (in_tdata[2*PRICE_BITS-1:PRICE_BITS]),
    .cmd         (cmd),
    .sts         (sts),
    .flags       (out_tuser),
    .window_peak (out_tdata)
  );

endmodule

### design/dfp_ctrl.sv
// Controller state machine: sequences load, window scan, drain, multiply and finish.
module dfp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  dfp_pkg::dfp_sts_t sts,
  output dfp_pkg::dfp_cmd_t cmd
);

  dfp_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            fin_ok;

  assign fin_ok = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dfp_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.filled ? dfp_pkg::S_SCAN : dfp_pkg::S_MUL;
        end
      end
      dfp_pkg::S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = dfp_pkg::S_DRAIN;
        end
      end
      dfp_pkg::S_DRAIN: state_nxt = dfp_pkg::S_MUL;
      dfp_pkg::S_MUL:   state_nxt = dfp_pkg::S_FIN;
      dfp_pkg::S_FIN: begin
        if (fin_ok) begin
          state_nxt = dfp_pkg::S_IDLE;
        end
      end
      default: state_nxt = dfp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      dfp_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      dfp_pkg::S_SCAN:  cmd.scan = 1'b1;
      dfp_pkg::S_DRAIN: cmd      = '0;
      dfp_pkg::S_MUL:   cmd.mul  = 1'b1;
      dfp_pkg::S_FIN:   cmd.fin  = fin_ok;
      default:          cmd      = '0;
    endcase
  end

  // Hold the result word until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/dfp_dp.sv
// Datapath: price ring memory, peak scan comparator, threshold multipliers, result register.
module dfp_dp #(
  parameter int WINDOW_DEPTH = dfp_pkg::DEF_WINDOW_DEPTH,
  parameter int WARMUP       = dfp_pkg::DEF_WARMUP,
  parameter int PRICE_BITS   = dfp_pkg::DEF_PRICE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_addr,
  input  logic [dfp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic [PRICE_BITS-1:0]             close_price,
  input  logic                              holding,
  input  logic [PRICE_BITS-1:0]             entry_price,
  input  dfp_pkg::dfp_cmd_t                 cmd,
  output dfp_pkg::dfp_sts_t                 sts,
  output logic [dfp_pkg::FLAG_BITS-1:0]     flags,
  output logic [dfp_pkg::PEAK_OUT_BITS-1:0] window_peak
);

  localparam int PB        = PRICE_BITS;
  localparam int AW        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int COUNT_MAX = (WINDOW_DEPTH > 127) ? WINDOW_DEPTH : 127;
  localparam int CW        = $clog2(COUNT_MAX + 1);
  localparam int PW        = PB + 14;
  localparam int RW        = PB + 7;

  logic [dfp_pkg::LOOKBACK_BITS-1:0]  lookback_r;
  logic [dfp_pkg::THRESHOLD_BITS-1:0] threshold_r;

  logic [PB-1:0] mem [WINDOW_DEPTH];
  logic [PB-1:0] rd_data_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] wptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] kcnt_r;

  logic [PB-1:0] price_r, entry_r, peak_r;
  logic          hold_r, ge_r;
  logic [PW-1:0] prod0_r, prod1_r;
  logic [RW-1:0] prod2_r, prod3_r;

  logic [dfp_pkg::FLAG_BITS-1:0] flags_r;
  logic [PB-1:0]                 peak_out_r;

  logic [CW-1:0]                      lb_ext, eff_l;
  logic [dfp_pkg::THRESHOLD_BITS-1:0] eff_th;
  logic                               warm;
  logic [PB-1:0]                      gain;
  logic                               buy, sell, reason;
  logic [PB+dfp_pkg::PEAK_OUT_BITS-1:0] peak_ext;

  // Effective lookback clamped to 1..WINDOW_DEPTH
  always_comb begin
    lb_ext = CW'(lookback_r);
    if (lb_ext == '0) begin
      eff_l = CW'(1);
    end else if (lb_ext > CW'(WINDOW_DEPTH)) begin
      eff_l = CW'(WINDOW_DEPTH);
    end else begin
      eff_l = lb_ext;
    end
  end

  assign eff_th = (threshold_r > dfp_pkg::BP_ONE) ? dfp_pkg::BP_ONE : threshold_r;
  assign warm   = count_r >= CW'(WARMUP);
  assign gain   = price_r - entry_r;

  assign sts.filled    = count_r >= eff_l;
  assign sts.scan_last = kcnt_r == eff_l;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookback_r  <= dfp_pkg::LOOKBACK_RST;
      threshold_r <= dfp_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      case (dfp_pkg::cfg_reg_t'(cfg_addr))
        dfp_pkg::REG_LOOKBACK:  lookback_r  <= cfg_wdata[dfp_pkg::LOOKBACK_BITS-1:0];
        dfp_pkg::REG_THRESHOLD: threshold_r <= cfg_wdata;
        default:                lookback_r  <= lookback_r;
      endcase
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      mem[wptr_r] <= price_r;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      kcnt_r   <= '0;
      rd_ptr_r <= '0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        kcnt_r   <= CW'(1);
        rd_ptr_r <= (wptr_r == '0) ? AW'(WINDOW_DEPTH - 1) : wptr_r - AW'(1);
      end else if (cmd.scan) begin
        kcnt_r   <= kcnt_r + CW'(1);
        rd_ptr_r <= (rd_ptr_r == '0) ? AW'(WINDOW_DEPTH - 1) : rd_ptr_r - AW'(1);
      end
      if (cmd.fin) begin
        wptr_r <= (wptr_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr_r + AW'(1);
        if (count_r < CW'(COUNT_MAX)) begin
          count_r <= count_r + CW'(1);
        end
      end
    end
  end

  // Capture the item, then fold each returned price into the running peak
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      price_r <= close_price;
      entry_r <= entry_price;
      hold_r  <= holding;
      peak_r  <= '0;
    end else if (rd_vld_r && (rd_data_r > peak_r)) begin
      peak_r <= rd_data_r;
    end
  end

  // Cross-multiplied threshold terms
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      ge_r    <= price_r >= entry_r;
      prod0_r <= PW'(hold_r ? gain : price_r) * PW'(dfp_pkg::BP_ONE);
      prod1_r <= hold_r ? PW'(entry_r) * PW'(eff_th)
                        : PW'(peak_r) * PW'(dfp_pkg::BP_ONE - eff_th);
      prod2_r <= RW'(gain) * RW'(dfp_pkg::PCT_ONE);
      prod3_r <= RW'(entry_r) * RW'(dfp_pkg::TARGET_GAIN_PCT);
    end
  end

  assign buy    = !hold_r && sts.filled && warm && (prod0_r <= prod1_r);
  assign sell   = hold_r && ge_r && (prod0_r >= prod1_r);
  assign reason = hold_r && ge_r && (prod2_r >= prod3_r);

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      flags_r    <= {reason, sell, buy};
      peak_out_r <= peak_r;
    end
  end

  assign peak_ext    = {{dfp_pkg::PEAK_OUT_BITS{1'b0}}, peak_out_r};
  assign window_peak = peak_ext[dfp_pkg::PEAK_OUT_BITS-1:0];
  assign flags       = flags_r;

endmodule
